FILE: rtl/lfu_pkg.sv
// Package for the LFU cache policy unit: sizes, widths and the sequencer state type.
// Depends on nothing; used by rtl/lfu_cache_policy_unit.sv.
package lfu_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned KeyBits = 32;
  localparam int unsigned WordW = 32;
  localparam int unsigned StampW = 48;
  localparam int unsigned CapW = 5;
  localparam int unsigned OccW = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  localparam logic OpSet = 1'b0;
  localparam logic OpGet = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StLast,
    StWrite
  } state_e;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [WordW-1:0] value;
    logic [WordW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;
endpackage

FILE: rtl/lfu_cache_policy_unit.sv
// LFU cache policy unit: key-value store with least-frequently-used eviction.
// Depends on rtl/lfu_pkg.sv.
//
// An item is taken when start_i is high and busy_o is low. Each item reads the
// entry memory once per entry, one entry per cycle, through the single read
// port of the entry memory.
// A get gives one result beat on valid_o for one cycle; a set gives none.
// The receiver cannot stall: results must be taken when shown.
module lfu_cache_policy_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic op_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [4:0] cfg_data_i,
  output logic valid_o,
  output logic hit_o,
  output logic signed [31:0] data_o
);
  localparam logic [lfu_pkg::IdxW:0] LastIdx = (lfu_pkg::IdxW+1)'(lfu_pkg::Entries - 1);

  lfu_pkg::entry_t mem_q [lfu_pkg::Entries];
  lfu_pkg::entry_t rd_q;
  logic [lfu_pkg::IdxW-1:0] rd_addr;
  logic mem_we;
  logic [lfu_pkg::IdxW-1:0] wr_addr;
  lfu_pkg::entry_t wr_data;

  lfu_pkg::state_e state_q, state_d;
  logic [lfu_pkg::Entries-1:0] valid_q, valid_d;
  logic [lfu_pkg::CapW-1:0] cap_q, cap_d;
  logic [lfu_pkg::OccW-1:0] occ_q, occ_d;
  logic [lfu_pkg::StampW-1:0] stamp_q, stamp_d;
  logic [lfu_pkg::IdxW:0] cnt_q, cnt_d;
  logic [lfu_pkg::IdxW-1:0] chk_q, chk_d;
  logic op_q, op_d;
  logic [lfu_pkg::KeyBits-1:0] key_q, key_d;
  logic [lfu_pkg::WordW-1:0] val_q, val_d;
  logic hit_q, hit_d;
  logic [lfu_pkg::IdxW-1:0] hidx_q, hidx_d;
  lfu_pkg::entry_t hent_q, hent_d;
  logic vic_ok_q, vic_ok_d;
  logic [lfu_pkg::IdxW-1:0] vidx_q, vidx_d;
  logic [lfu_pkg::WordW-1:0] vcnt_q, vcnt_d;
  logic [lfu_pkg::StampW-1:0] vstamp_q, vstamp_d;
  logic out_v_q, out_v_d;
  logic out_hit_q, out_hit_d;
  logic [lfu_pkg::WordW-1:0] out_data_q, out_data_d;

  logic [lfu_pkg::CapW-1:0] eff_cap;
  logic free_ok;
  logic [lfu_pkg::IdxW-1:0] free_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    eff_cap = cap_q;
    if (cap_q == '0) begin
      eff_cap = lfu_pkg::CapW'(1);
    end else if (32'(cap_q) > lfu_pkg::Entries) begin
      eff_cap = lfu_pkg::CapW'(lfu_pkg::Entries);
    end
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = lfu_pkg::Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_ok = 1'b1;
        free_idx = lfu_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    logic [lfu_pkg::WordW-1:0] ncnt;
    logic evict;
    logic [lfu_pkg::IdxW-1:0] slot;
    state_d = state_q;
    valid_d = valid_q;
    cap_d = cap_q;
    occ_d = occ_q;
    stamp_d = stamp_q;
    cnt_d = cnt_q;
    chk_d = chk_q;
    op_d = op_q;
    key_d = key_q;
    val_d = val_q;
    hit_d = hit_q;
    hidx_d = hidx_q;
    hent_d = hent_q;
    vic_ok_d = vic_ok_q;
    vidx_d = vidx_q;
    vcnt_d = vcnt_q;
    vstamp_d = vstamp_q;
    out_v_d = 1'b0;
    out_hit_d = out_hit_q;
    out_data_d = out_data_q;
    rd_addr = cnt_q[lfu_pkg::IdxW-1:0];
    mem_we = 1'b0;
    wr_addr = hidx_q;
    wr_data = hent_q;
    busy_o = (state_q != lfu_pkg::StIdle);
    cfg_ready_o = (state_q == lfu_pkg::StIdle);
    ncnt = '0;
    evict = 1'b0;
    slot = '0;
    if (cfg_valid_i && cfg_ready_o) begin
      cap_d = cfg_data_i;
    end
    unique case (state_q)
      lfu_pkg::StIdle: begin
        rd_addr = '0;
        if (start_i) begin
          op_d = op_i;
          key_d = key_i;
          val_d = value_i;
          hit_d = 1'b0;
          vic_ok_d = 1'b0;
          cnt_d = (lfu_pkg::IdxW+1)'(1);
          chk_d = '0;
          state_d = lfu_pkg::StScan;
        end
      end
      lfu_pkg::StScan, lfu_pkg::StLast: begin
        if (valid_q[chk_q]) begin
          if (rd_q.key == key_q && !hit_q) begin
            hit_d = 1'b1;
            hidx_d = chk_q;
            hent_d = rd_q;
          end
          if (!vic_ok_q || rd_q.count < vcnt_q ||
              (rd_q.count == vcnt_q && rd_q.stamp < vstamp_q)) begin
            vic_ok_d = 1'b1;
            vidx_d = chk_q;
            vcnt_d = rd_q.count;
            vstamp_d = rd_q.stamp;
          end
        end
        chk_d = chk_q + lfu_pkg::IdxW'(1);
        if (state_q == lfu_pkg::StLast) begin
          state_d = lfu_pkg::StWrite;
        end else begin
          if (cnt_q == LastIdx) begin
            state_d = lfu_pkg::StLast;
          end
          cnt_d = cnt_q + (lfu_pkg::IdxW+1)'(1);
        end
      end
      lfu_pkg::StWrite: begin
        state_d = lfu_pkg::StIdle;
        ncnt = (hent_q.count == '1) ? hent_q.count : hent_q.count + lfu_pkg::WordW'(1);
        if (hit_q) begin
          mem_we = 1'b1;
          wr_addr = hidx_q;
          wr_data.key = hent_q.key;
          wr_data.count = ncnt;
          wr_data.stamp = stamp_q;
          wr_data.value = (op_q == lfu_pkg::OpSet) ? val_q : hent_q.value;
          stamp_d = stamp_q + lfu_pkg::StampW'(1);
        end
        if (op_q == lfu_pkg::OpGet) begin
          out_v_d = 1'b1;
          out_hit_d = hit_q;
          out_data_d = hit_q ? hent_q.value : '1;
        end else if (!hit_q) begin
          evict = (occ_q >= eff_cap) && vic_ok_q;
          slot = free_idx;
          if (evict && (!free_ok || vidx_q < free_idx)) begin
            slot = vidx_q;
          end
          if (evict || free_ok) begin
            mem_we = 1'b1;
            wr_addr = slot;
            wr_data.key = key_q;
            wr_data.value = val_q;
            wr_data.count = lfu_pkg::WordW'(1);
            wr_data.stamp = stamp_q;
            stamp_d = stamp_q + lfu_pkg::StampW'(1);
            if (evict) begin
              valid_d[vidx_q] = 1'b0;
            end
            valid_d[slot] = 1'b1;
            occ_d = (evict ? ((occ_q > '0) ? occ_q - lfu_pkg::OccW'(1) : occ_q) : occ_q)
                    + lfu_pkg::OccW'(1);
          end
        end
      end
      default: state_d = lfu_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::StIdle;
      valid_q <= '0;
      cap_q <= lfu_pkg::CapReset;
      occ_q <= '0;
      stamp_q <= '0;
      cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cap_q <= cap_d;
      occ_q <= occ_d;
      stamp_q <= stamp_d;
      cnt_q <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q <= chk_d;
    op_q <= op_d;
    key_q <= key_d;
    val_q <= val_d;
    hit_q <= hit_d;
    hidx_q <= hidx_d;
    hent_q <= hent_d;
    vic_ok_q <= vic_ok_d;
    vidx_q <= vidx_d;
    vcnt_q <= vcnt_d;
    vstamp_q <= vstamp_d;
    out_hit_q <= out_hit_d;
    out_data_q <= out_data_d;
  end

  assign valid_o = out_v_q;
  assign hit_o = out_hit_q;
  assign data_o = out_data_q;
endmodule
